FILE: rtl/core/sfp_pkg.sv
package sfp_pkg;

  // Default payload buffer capacity in bytes
  localparam int BUF_SIZE_DEF = 63;

  localparam logic [7:0] HDR_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] HDR_M      = 8'h4D;  // 'M'
  localparam logic [7:0] HDR_ARROW  = 8'h3E;  // '>'

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_DOLLAR = 3'd1,
    ST_M      = 3'd2,
    ST_ARROW  = 3'd3,
    ST_SIZE   = 3'd4,
    ST_BODY   = 3'd5,
    ST_EMIT   = 3'd6
  } parse_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_len;    // size byte accepted, frame opened
    logic load_cmd;    // command byte accepted
    logic store_byte;  // payload byte accepted
    logic rd_start;    // checksum good, fetch first payload byte
    logic out_load;    // load result into output register
  } sfp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_dollar;
    logic is_m;
    logic is_arrow;
    logic size_ok;
    logic body_more;
    logic csum_ok;
    logic emit_last;
    logic out_free;
  } sfp_status_t;

endpackage

FILE: rtl/core/sfp_ram.sv
module sfp_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/sfp_ctrl.sv
module sfp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sfp_pkg::sfp_status_t sts,
  output sfp_pkg::sfp_cmd_t   cmd
);

  import sfp_pkg::*;

  parse_state_t state_r;
  parse_state_t state_nxt;
  logic         acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b0;
    acc       = in_valid;
    case (state_r)
      ST_DOLLAR: begin
        if (acc) state_nxt = sts.is_m ? ST_M : ST_IDLE;
      end
      ST_M: begin
        if (acc) state_nxt = sts.is_arrow ? ST_ARROW : ST_IDLE;
      end
      ST_ARROW: begin
        if (acc) begin
          if (sts.size_ok) begin
            cmd.load_len = 1'b1;
            state_nxt    = ST_SIZE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SIZE: begin
        if (acc) begin
          cmd.load_cmd = 1'b1;
          state_nxt    = ST_BODY;
        end
      end
      ST_BODY: begin
        if (acc) begin
          if (sts.body_more) begin
            cmd.store_byte = 1'b1;
          end else if (sts.csum_ok) begin
            cmd.rd_start = 1'b1;
            state_nxt    = ST_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        in_stall = 1'b1;
        acc      = 1'b0;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.emit_last) state_nxt = ST_IDLE;
        end
      end
      default: begin
        if (acc) state_nxt = sts.is_dollar ? ST_DOLLAR : ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/sfp_dp.sv
module sfp_dp #(
  parameter int BUF_SIZE = sfp_pkg::BUF_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_rx_byte,
  input  sfp_pkg::sfp_cmd_t    cmd,
  output sfp_pkg::sfp_status_t sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_command,
  output logic [5:0]           out_frame_size,
  output logic [5:0]           out_payload_index,
  output logic [7:0]           out_payload_byte,
  output logic                 out_has_data,
  output logic                 out_last
);

  import sfp_pkg::*;

  localparam int AW = (BUF_SIZE > 1) ? $clog2(BUF_SIZE) : 1;

  logic [5:0] len_r;
  logic [5:0] off_r;
  logic [7:0] csum_r;
  logic [7:0] cmd_byte_r;

  logic       ov_r;
  logic [7:0] o_cmd_r;
  logic [5:0] o_size_r;
  logic [5:0] o_idx_r;
  logic [7:0] o_byte_r;
  logic       o_has_r;
  logic       o_last_r;

  logic [5:0] off_inc;
  logic       has_data;
  logic       rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0] rd_data;

  assign off_inc  = off_r + 6'd1;
  assign has_data = (len_r != 6'd0);

  assign sts.is_dollar = (in_rx_byte == HDR_DOLLAR);
  assign sts.is_m      = (in_rx_byte == HDR_M);
  assign sts.is_arrow  = (in_rx_byte == HDR_ARROW);
  assign sts.size_ok   = (in_rx_byte <= 8'(BUF_SIZE));
  assign sts.body_more = (off_r < len_r);
  assign sts.csum_ok   = (csum_r == in_rx_byte);
  assign sts.emit_last = !has_data || (off_inc == len_r);
  assign sts.out_free  = !ov_r || !out_stall;

  // Prefetch: first byte on checksum match, next byte on each result load but the last
  assign rd_en   = cmd.rd_start || (cmd.out_load && !sts.emit_last);
  assign rd_addr = cmd.rd_start ? '0 : off_inc[AW-1:0];

  sfp_ram #(
    .WIDTH (8),
    .DEPTH (BUF_SIZE)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.store_byte),
    .wr_addr (off_r[AW-1:0]),
    .wr_data (in_rx_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      off_r      <= '0;
      csum_r     <= '0;
      cmd_byte_r <= '0;
    end else begin
      if (cmd.load_len) begin
        len_r  <= in_rx_byte[5:0];
        off_r  <= '0;
        csum_r <= in_rx_byte;
      end
      if (cmd.load_cmd) begin
        cmd_byte_r <= in_rx_byte;
        csum_r     <= csum_r ^ in_rx_byte;
      end
      if (cmd.store_byte) begin
        csum_r <= csum_r ^ in_rx_byte;
        off_r  <= off_inc;
      end
      if (cmd.rd_start) begin
        off_r <= '0;
      end
      if (cmd.out_load && !sts.emit_last) begin
        off_r <= off_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.out_load) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_cmd_r  <= cmd_byte_r;
      o_size_r <= len_r;
      o_idx_r  <= off_r;
      o_byte_r <= has_data ? rd_data : 8'd0;
      o_has_r  <= has_data;
      o_last_r <= sts.emit_last;
    end
  end

  assign out_valid         = ov_r;
  assign out_command       = o_cmd_r;
  assign out_frame_size    = o_size_r;
  assign out_payload_index = o_idx_r;
  assign out_payload_byte  = o_byte_r;
  assign out_has_data      = o_has_r;
  assign out_last          = o_last_r;

endmodule

FILE: rtl/core/serial_frame_parser.sv
// Serial frame parser: hunts a received byte stream for frames of the form
//   '$' 'M' '>' size command payload[size] checksum
// Input channel: one byte per transfer on in_rx_byte (in_valid / in_stall).
// A byte is taken every cycle while the parser is hunting or receiving.
// Output channel: one transfer per payload byte of a frame whose checksum
// (XOR of size, command and payload) matches; one data-less transfer with
// out_last set for an empty frame. Bad checksum, oversized frame or a wrong
// header byte drop silently back to hunting (no resync on the wrong byte).
// After the checksum transfer the first payload byte is read from the RAM,
// then the output register loads it in ST_EMIT. Emission runs at one result
// per cycle while the output is not stalled (registered read, next byte
// prefetched as each result but the last loads); in_stall stays high meanwhile.
// Stall on the output freezes the output register and the emission; the
// input stays stalled until the final result of the frame is loaded.
// Reset (rst_n low, synchronous) returns the parser to hunting and empties
// the output register; payload RAM contents are not cleared.
module serial_frame_parser #(
  parameter int BUF_SIZE = sfp_pkg::BUF_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_command,
  output logic [5:0] out_frame_size,
  output logic [5:0] out_payload_index,
  output logic [7:0] out_payload_byte,
  output logic       out_has_data,
  output logic       out_last
);

  import sfp_pkg::*;

  sfp_cmd_t    cmd;
  sfp_status_t sts;

  // Header matching, frame sequencing and emission control
  sfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Length/offset/checksum registers, payload RAM and output register
  sfp_dp #(
    .BUF_SIZE (BUF_SIZE)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_rx_byte        (in_rx_byte),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_command       (out_command),
    .out_frame_size    (out_frame_size),
    .out_payload_index (out_payload_index),
    .out_payload_byte  (out_payload_byte),
    .out_has_data      (out_has_data),
    .out_last          (out_last)
  );

endmodule
